>>> src/ust_pkg.sv
// shared types and constants for the unordered set table
`default_nettype none

package ust_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 11;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 10;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  total;
  } res_t;

endpackage

`default_nettype wire

>>> src/ust_ram.sv
// single-port-write, registered-read memory holding the table entries
`default_nettype none

module ust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/ust_engine.sv
// operation sequencer: add, scan for find and delete, swap-remove, clear
`default_nettype none

module ust_engine (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [ust_pkg::CNT_W-1:0] capacity,
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire ust_pkg::kind_t           req_kind,
  input  wire logic [ust_pkg::VAL_W-1:0] req_value,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output ust_pkg::res_t                 res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  ust_pkg::kind_t               kind_r, kind_nxt;
  logic [ust_pkg::VAL_W-1:0]    value_r, value_nxt;
  logic [ust_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [ust_pkg::CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic [ust_pkg::ADDR_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [ust_pkg::ADDR_W-1:0]   hit_idx_r, hit_idx_nxt;
  ust_pkg::res_t                res_r, res_nxt;

  logic                         wr_en, rd_en;
  logic [ust_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
  logic [ust_pkg::VAL_W-1:0]    wr_data, rd_data;
  logic [ust_pkg::CNT_W-1:0]    eff_cap, last_idx;
  logic                         hit;

  ust_ram #(
    .WIDTH (ust_pkg::VAL_W),
    .DEPTH (ust_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign eff_cap  = (capacity > ust_pkg::CAP_MAX) ? ust_pkg::CAP_MAX : capacity;
  assign last_idx = count_r - ust_pkg::CNT_W'(1);
  assign hit      = cmp_vld_r && (rd_data == value_r);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    hit_idx_nxt = hit_idx_r;
    res_nxt     = res_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[ust_pkg::ADDR_W-1:0];
    wr_data     = req_value;
    rd_en       = 1'b0;
    rd_addr     = rd_idx_r[ust_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          kind_nxt         = req_kind;
          value_nxt        = req_value;
          res_nxt.status   = ust_pkg::ST_OK;
          res_nxt.position = '0;
          unique case (req_kind)
            ust_pkg::KIND_ADD: begin
              if (count_r >= eff_cap) begin
                res_nxt.status = ust_pkg::ST_FULL;
                res_nxt.total  = count_r;
              end else begin
                wr_en            = 1'b1;
                res_nxt.position = count_r[ust_pkg::POS_W-1:0];
                count_nxt        = count_r + ust_pkg::CNT_W'(1);
                res_nxt.total    = count_r + ust_pkg::CNT_W'(1);
              end
              state_nxt = S_DONE;
            end
            ust_pkg::KIND_CLEAR: begin
              count_nxt     = '0;
              res_nxt.total = '0;
              state_nxt     = S_DONE;
            end
            ust_pkg::KIND_FIND, ust_pkg::KIND_DELETE: begin
              rd_idx_nxt  = '0;
              cmp_vld_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        // one read issued per cycle, compared the cycle after
        if (hit) begin
          cmp_vld_nxt = 1'b0;
          if (kind_r == ust_pkg::KIND_FIND) begin
            res_nxt.position = cmp_idx_r;
            res_nxt.total    = count_r;
            state_nxt        = S_DONE;
          end else begin
            // fetch the last entry to fill the hole
            hit_idx_nxt = cmp_idx_r;
            rd_en       = 1'b1;
            rd_addr     = last_idx[ust_pkg::ADDR_W-1:0];
            state_nxt   = S_MOVE;
          end
        end else if (rd_idx_r < count_r) begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[ust_pkg::ADDR_W-1:0];
          rd_idx_nxt  = rd_idx_r + ust_pkg::CNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            res_nxt.status = ust_pkg::ST_NOT_FOUND;
            res_nxt.total  = count_r;
            state_nxt      = S_DONE;
          end
        end
      end

      S_MOVE: begin
        wr_en         = 1'b1;
        wr_addr       = hit_idx_r;
        wr_data       = rd_data;
        count_nxt     = last_idx;
        res_nxt.total = last_idx;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    value_r   <= value_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    res_r     <= res_nxt;
  end

endmodule

`default_nettype wire

>>> src/unordered_set_table.sv
// top level of the unordered set table: capacity register, engine and output register
`default_nettype none

// unordered table of up to 1024 signed 32-bit values with an entry count.
// each request on the in_ stream is add, find, delete or clear and gives
// exactly one result on the out_ stream carrying a status, a position and
// the entry count after the operation. add appends at the end, or reports
// full once the count reaches the capacity register (limited to the table
// depth); find returns the lowest index holding the value; delete moves
// the last entry into the hole and shrinks the count; clear empties the
// table at once. requests are handled one at a time: add and clear go
// from acceptance straight to the result register, find scans up from
// index 0 and stops early on a match; delete scans likewise and, on a
// match, moves the last entry into the hole. the scan is paced by the
// single read port of the entry memory, which delivers one entry per
// cycle to the comparator. a finished result sits in the output
// register, so the next request is accepted while it waits. the
// capacity register (reset 1024) is written over the cfg_ channel and
// should only be changed while no request is in flight.

module unordered_set_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // capacity register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data,
  // requests
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [9:0] position, [20:10] entry_total, zero above
  output logic [1:0]       out_tuser   // [1:0] status
);

  logic [ust_pkg::CNT_W-1:0] capacity_r;
  logic                      out_valid_r;
  ust_pkg::res_t             out_res_r;

  logic                      res_valid, res_ready;
  ust_pkg::res_t             res;

  // capacity is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= ust_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      capacity_r <= cfg_data;
    end
  end

  ust_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (ust_pkg::kind_t'(in_tuser)),
    .req_value (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register takes a result when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {3'b000, out_res_r.total, out_res_r.position};

endmodule

`default_nettype wire
